// ----- rtl/core/kncl_pkg.sv -----
// Shared types, sizes and register codes of the k-nearest candidate list.
// Used by kncl_cell, k_nearest_candidate_list and kncl_checker.
// Depends on nothing.
package kncl_pkg;

   // Store size and field widths
   localparam int MAX_NEIGHBOURS = 32;
   localparam int NODE_BITS      = 10;
   localparam int DIST_BITS      = 32;
   localparam int COUNT_BITS     = $clog2(MAX_NEIGHBOURS + 1);
   localparam int SLOT_BITS      = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;

   // Configuration port
   localparam int SELF_NODE_BITS = 10;
   localparam int LIST_SIZE_BITS = 6;
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 10;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SELF_NODE = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LIST_SIZE = CSR_INDEX_BITS'(1);

   localparam logic [LIST_SIZE_BITS-1:0] LIST_SIZE_RESET = LIST_SIZE_BITS'(20);

   // Operation broadcast to every slot of the chain
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_SORT,
      CELL_SHIFT
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        fill;   // store not yet full: top slot may grow
      logic        phase;  // odd-even sort phase
   } cell_cmd_type;

   typedef struct packed {
      logic [NODE_BITS-1:0] idx;
      logic [DIST_BITS-1:0] distance;
   } item_type;

   typedef struct packed {
      logic                 valid;
      logic [NODE_BITS-1:0] idx;
      logic [DIST_BITS-1:0] distance;
   } entry_type;

   // True when a belongs after b in ascending index order; empty slots go last
   function automatic logic entry_after(entry_type a, entry_type b);
      entry_after = (!a.valid && b.valid) || (a.valid && b.valid && (a.idx > b.idx));
   endfunction

endpackage

// ----- rtl/core/kncl_cell.sv -----
// One slot of the candidate chain: holds one kept entry and trades it with its neighbors.
// Uses types and the ordering function of kncl_pkg.
// Instantiated by k_nearest_candidate_list.
module kncl_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  kncl_pkg::cell_cmd_type cmd,
   input  kncl_pkg::item_type   item,
   input  logic                 slot_odd,
   input  kncl_pkg::entry_type  left_ent,
   input  logic                 left_lt,
   input  kncl_pkg::entry_type  right_ent,
   output kncl_pkg::entry_type  ent,
   output logic                 lt,
   output logic                 dup,
   output logic                 beats
);

   logic                           valid_ff;
   logic [kncl_pkg::NODE_BITS-1:0] idx_ff;
   logic [kncl_pkg::DIST_BITS-1:0] dist_ff;
   kncl_pkg::entry_type            ent_in;

   assign ent = {valid_ff, idx_ff, dist_ff};

   // Rank against the new item: below it in (distance up, index down) order
   assign lt = valid_ff && ((dist_ff < item.distance) ||
                            ((dist_ff == item.distance) && (idx_ff > item.idx)));
   assign dup = valid_ff && (idx_ff == item.idx);

   // Top of the kept run with a distance the new item strictly undercuts
   assign beats = valid_ff && !right_ent.valid && (item.distance < dist_ff);

   // Pick the next content of this slot
   always_comb begin
      ent_in = ent;
      case (cmd.op)
         kncl_pkg::CELL_INSERT: begin
            if (lt || (!cmd.fill && !valid_ff)) begin
               ent_in = ent;
            end else if (left_lt) begin
               ent_in = {1'b1, item.idx, item.distance};
            end else begin
               ent_in = left_ent;
            end
         end
         kncl_pkg::CELL_SORT: begin
            if (slot_odd == cmd.phase) begin
               if (kncl_pkg::entry_after(ent, right_ent)) begin
                  ent_in = right_ent;
               end
            end else begin
               if (kncl_pkg::entry_after(left_ent, ent)) begin
                  ent_in = left_ent;
               end
            end
         end
         kncl_pkg::CELL_SHIFT: begin
            ent_in = right_ent;
         end
         default: begin
            ent_in = ent;
         end
      endcase
   end

   // Hold the valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ent_in.valid;
      end
   end

   // Hold the payload
   always_ff @(posedge clock) begin
      idx_ff  <= ent_in.idx;
      dist_ff <= ent_in.distance;
   end

endmodule

// ----- rtl/core/k_nearest_candidate_list.sv -----
// Top level of the k-nearest candidate list: configuration, control and the slot chain.
// Depends on kncl_pkg and kncl_cell.
//
//   channel  ports                                   handshake
//   -------  --------------------------------------  ---------------------------------
//   request  start, busy, req_node_index,            taken when start=1 and busy=0
//            req_distance, req_last_node
//   response rsp_strobe, rsp_neighbour_index,        items back to back, no back-pressure
//            rsp_valid_res, rsp_last_of_list
//   csr      csr_valid, csr_ready, csr_index,        written when csr_valid and csr_ready
//            csr_wdata
//
// A candidate that is not the last of its row leaves busy low: every slot compares it with
// its own entry and the chain inserts it in place, if it is kept, in the same cycle.
// The last candidate is handled the same way, then the chain runs odd-even exchange phases
// to order by index, then shifts out one result per cycle (one result for an empty list);
// busy stays high from that item until the last result is shifted out.
// Reset is synchronous: it empties the chain, resets control and CSRs, not data registers.
// Results cannot be stalled; csr_ready is always high.
module k_nearest_candidate_list (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [kncl_pkg::NODE_BITS-1:0]      req_node_index,
   input  logic [kncl_pkg::DIST_BITS-1:0]      req_distance,
   input  logic                                req_last_node,
   output logic                                rsp_strobe,
   output logic [kncl_pkg::NODE_BITS-1:0]      rsp_neighbour_index,
   output logic                                rsp_valid_res,
   output logic                                rsp_last_of_list,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [kncl_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [kncl_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SORT,
      ST_EMIT
   } state_type;

   localparam int MAX = kncl_pkg::MAX_NEIGHBOURS;

   state_type                                state_ff, state_in;
   logic [kncl_pkg::SLOT_BITS-1:0]           phase_cnt_ff, phase_cnt_in;
   logic [kncl_pkg::COUNT_BITS-1:0]          kept_count_ff, kept_count_in;
   logic                                     rsp_strobe_ff, rsp_strobe_in;
   logic [kncl_pkg::NODE_BITS-1:0]           rsp_index_ff, rsp_index_in;
   logic                                     rsp_valid_ff, rsp_valid_in;
   logic                                     rsp_last_ff, rsp_last_in;
   logic [kncl_pkg::SELF_NODE_BITS-1:0]      self_node_ff;
   logic [kncl_pkg::LIST_SIZE_BITS-1:0]      list_size_ff;

   logic [kncl_pkg::COUNT_BITS-1:0]          cap;
   logic                                     accept;
   logic                                     fill;
   logic                                     do_update;
   logic                                     dup_any;
   logic                                     replace_ok;
   kncl_pkg::cell_cmd_type                   cmd;
   kncl_pkg::item_type                       item;

   kncl_pkg::entry_type                      ent       [MAX];
   kncl_pkg::entry_type                      left_ent  [MAX];
   kncl_pkg::entry_type                      right_ent [MAX];
   logic [MAX-1:0]                           lt_vec;
   logic [MAX-1:0]                           left_lt;
   logic [MAX-1:0]                           dup_vec;
   logic [MAX-1:0]                           beats_vec;

   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         self_node_ff <= '0;
         list_size_ff <= kncl_pkg::LIST_SIZE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            kncl_pkg::CSR_SELF_NODE: self_node_ff <= csr_wdata[kncl_pkg::SELF_NODE_BITS-1:0];
            kncl_pkg::CSR_LIST_SIZE: list_size_ff <= csr_wdata[kncl_pkg::LIST_SIZE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Clamp the list size to 1..MAX
   always_comb begin
      if (list_size_ff == '0) begin
         cap = kncl_pkg::COUNT_BITS'(1);
      end else if (int'(list_size_ff) > MAX) begin
         cap = kncl_pkg::COUNT_BITS'(MAX);
      end else begin
         cap = kncl_pkg::COUNT_BITS'(list_size_ff);
      end
   end

   // Decide whether the incoming item enters the chain
   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign item       = {req_node_index, req_distance};
   assign dup_any    = |dup_vec;
   assign replace_ok = |beats_vec;
   assign fill       = (kept_count_ff < cap);
   assign do_update  = accept && (req_node_index != kncl_pkg::NODE_BITS'(self_node_ff)) &&
                       !dup_any && (fill || replace_ok);

   // Broadcast the chain operation
   always_comb begin
      cmd.fill  = fill;
      cmd.phase = phase_cnt_ff[0];
      case (state_ff)
         ST_IDLE: cmd.op = do_update ? kncl_pkg::CELL_INSERT : kncl_pkg::CELL_HOLD;
         ST_SORT: cmd.op = kncl_pkg::CELL_SORT;
         ST_EMIT: cmd.op = kncl_pkg::CELL_SHIFT;
         default: cmd.op = kncl_pkg::CELL_HOLD;
      endcase
   end

   // Slot chain
   for (genvar i = 0; i < MAX; i++) begin : g_slot
      if (i == 0) begin : g_head
         assign left_ent[i] = {1'b1, {kncl_pkg::NODE_BITS{1'b0}}, {kncl_pkg::DIST_BITS{1'b0}}};
         assign left_lt[i]  = 1'b1;
      end else begin : g_body
         assign left_ent[i] = ent[i-1];
         assign left_lt[i]  = lt_vec[i-1];
      end
      if (i == MAX - 1) begin : g_tail
         assign right_ent[i] = '0;
      end else begin : g_inner
         assign right_ent[i] = ent[i+1];
      end

      kncl_cell u_slot (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .item      (item),
         .slot_odd  (1'(i % 2)),
         .left_ent  (left_ent[i]),
         .left_lt   (left_lt[i]),
         .right_ent (right_ent[i]),
         .ent       (ent[i]),
         .lt        (lt_vec[i]),
         .dup       (dup_vec[i]),
         .beats     (beats_vec[i])
      );
   end

   // Sequence the row: insert, order by index, drain
   always_comb begin
      state_in      = state_ff;
      phase_cnt_in  = phase_cnt_ff;
      kept_count_in = kept_count_ff;
      rsp_strobe_in = 1'b0;
      rsp_index_in  = rsp_index_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_last_in   = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (do_update && fill) begin
               kept_count_in = kept_count_ff + kncl_pkg::COUNT_BITS'(1);
            end
            if (accept && req_last_node) begin
               state_in     = ST_SORT;
               phase_cnt_in = '0;
            end
         end
         ST_SORT: begin
            phase_cnt_in = phase_cnt_ff + kncl_pkg::SLOT_BITS'(1);
            if (phase_cnt_ff == kncl_pkg::SLOT_BITS'(MAX - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_strobe_in = 1'b1;
            rsp_index_in  = ent[0].valid ? ent[0].idx : '0;
            rsp_valid_in  = ent[0].valid;
            rsp_last_in   = !right_ent[0].valid;
            if (!right_ent[0].valid) begin
               state_in      = ST_IDLE;
               kept_count_in = '0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_cnt_ff  <= '0;
         kept_count_ff <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_cnt_ff  <= phase_cnt_in;
         kept_count_ff <= kept_count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      rsp_index_ff <= rsp_index_in;
      rsp_valid_ff <= rsp_valid_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_neighbour_index = rsp_index_ff;
   assign rsp_valid_res       = rsp_valid_ff;
   assign rsp_last_of_list    = rsp_last_ff;

endmodule

// ----- rtl/core/kncl_checker.sv -----
// Port-level checks for k_nearest_candidate_list, attached by the bind below.
// Depends on kncl_pkg and the top level's ports.
module kncl_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic                                req_last_node,
   input logic                                rsp_strobe,
   input logic                                rsp_valid_res,
   input logic                                rsp_last_of_list,
   input logic [kncl_pkg::NODE_BITS-1:0]      rsp_neighbour_index
);

   // An empty list is reported by a single closing item with a zero index
   a_empty_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_valid_res |-> rsp_last_of_list && (rsp_neighbour_index == '0))
      else $error("empty-list item not a single closing item");

   // A last candidate puts the block to work on the list
   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_last_node |=> busy)
      else $error("busy not raised after last candidate");

   // Items of one list come out back to back
   a_list_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_of_list |=> rsp_strobe)
      else $error("gap inside a list");

   // The closing item frees the block
   a_close_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last_of_list |-> !busy)
      else $error("still busy after closing item");

   // No item outside a list drain
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("item without a pending list");

endmodule

bind k_nearest_candidate_list kncl_checker u_kncl_checker (
   .clock               (clock),
   .reset               (reset),
   .start               (start),
   .busy                (busy),
   .req_last_node       (req_last_node),
   .rsp_strobe          (rsp_strobe),
   .rsp_valid_res       (rsp_valid_res),
   .rsp_last_of_list    (rsp_last_of_list),
   .rsp_neighbour_index (rsp_neighbour_index)
);
